>>> hw/rtl/cnd_pkg.sv
// Shared constants, types and the shade table of the cross-neighbour despeckle block.
package cnd_pkg;

  // Default frame limits
  localparam int MAX_WIDTH_DEF  = 32;
  localparam int MAX_HEIGHT_DEF = 1024;

  // Configuration register layout and reset values
  localparam int WIDTH_REG_W  = 6;
  localparam int HEIGHT_REG_W = 11;
  localparam int WIDTH_RESET  = 30;
  localparam int HEIGHT_RESET = 20;
  localparam int MIN_DIM      = 2;
  localparam int CFG_INDEX_W  = 2;
  localparam int CFG_DATA_W   = 11;

  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

  // Payload field widths
  localparam int LEVEL_W     = 4;
  localparam int GLYPH_W     = 7;
  localparam int OUT_ROW_W   = 10;
  localparam int OUT_COL_W   = 5;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 32;

  // Depth of the queue between front and back
  localparam int QUEUE_DEPTH = 4;

  typedef logic [LEVEL_W-1:0] level_t;

  // Classification the front attaches to every pixel
  typedef struct packed {
    logic emit;      // pixel releases the one above it
    logic has_up;    // row above the released pixel exists
    logic row_end;   // last pixel of its row
    logic last_row;  // pixel lies in the final row of the frame
  } item_flags_t;

  // Map a level to its ASCII shade character
  function automatic logic [GLYPH_W-1:0] shade_glyph(input level_t lv);
    logic [GLYPH_W-1:0] g;
    case (lv)
      4'd0:    g = 7'h20;  // space
      4'd1:    g = 7'h2e;  // .
      4'd2:    g = 7'h27;  // apostrophe
      4'd3:    g = 7'h3a;  // :
      4'd4:    g = 7'h7e;  // ~
      4'd5:    g = 7'h2a;  // *
      4'd6:    g = 7'h3d;  // =
      4'd7:    g = 7'h26;  // &
      4'd8:    g = 7'h25;  // %
      4'd9:    g = 7'h23;  // #
      default: g = 7'h20;  // levels above nine show as space
    endcase
    return g;
  endfunction

endpackage

>>> hw/rtl/cross_neighbour_despeckle.sv
// A pixel below row 0 passes the queue register and the back sequencer states (idle, prime at
// column 0, calc) to the output register; row 0 pixels are only stored. The sequencer takes no
// new pixel until idle again, as it reads each line store through one registered port per step.
// The last pixel of a frame adds a flush of the final row before the next pixel is taken.
// Reset (synchronous, rst_n low) clears counters, queue, sequencer and output valid and sets
// frame_width 30, frame_height 20; line store contents are not cleared.
module cross_neighbour_despeckle import cnd_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,    // [3:0] pixel_level
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [3:0] filtered_level, [10:4] shade_glyph, [20:11] out_row, [25:21] out_col
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tlast,   // run_last
  output logic                   out_tuser,   // [0] frame_last
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int CW     = $clog2(MAX_WIDTH);
  localparam int RW     = (MAX_HEIGHT > 2) ? $clog2(MAX_HEIGHT) : 1;
  localparam int EW     = $clog2(MAX_WIDTH + 1);
  localparam int FLAG_W = $bits(item_flags_t);
  localparam int Q_W    = FLAG_W + RW + CW + LEVEL_W;

  logic [EW-1:0] eff_width;
  logic          push_valid, push_ready;
  level_t        push_pixel;
  logic [RW-1:0] push_row;
  logic [CW-1:0] push_col;
  item_flags_t   push_flags;
  logic          pop_valid, pop_ready;
  logic [Q_W-1:0] pop_data;
  level_t        q_pixel;
  logic [RW-1:0] q_row;
  logic [CW-1:0] q_col;
  item_flags_t   q_flags;

  // Accept and classify pixels
  cnd_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .eff_width  (eff_width),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_pixel (push_pixel),
    .push_row   (push_row),
    .push_col   (push_col),
    .push_flags (push_flags)
  );

  // Buffer classified pixels
  cnd_queue #(
    .DATA_W (Q_W),
    .DEPTH  (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  ({push_flags, push_row, push_col, push_pixel}),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  assign {q_flags, q_row, q_col, q_pixel} = pop_data;

  // Filter and emit results
  cnd_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .eff_width  (eff_width),
    .q_valid    (pop_valid),
    .q_ready    (pop_ready),
    .q_pixel    (q_pixel),
    .q_row      (q_row),
    .q_col      (q_col),
    .q_flags    (q_flags),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

>>> hw/rtl/cnd_front.sv
// Front end: configuration registers, raster counters and pixel classification.
module cnd_front import cnd_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
  localparam int CW = $clog2(MAX_WIDTH),
  localparam int RW = (MAX_HEIGHT > 2) ? $clog2(MAX_HEIGHT) : 1,
  localparam int EW = $clog2(MAX_WIDTH + 1),
  localparam int HW = $clog2(MAX_HEIGHT + 1)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,    // [3:0] pixel_level
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output logic [EW-1:0]          eff_width,
  output logic                   push_valid,
  input  logic                   push_ready,
  output level_t                 push_pixel,
  output logic [RW-1:0]          push_row,
  output logic [CW-1:0]          push_col,
  output item_flags_t            push_flags
);

  logic [WIDTH_REG_W-1:0]  frame_width_r;
  logic [HEIGHT_REG_W-1:0] frame_height_r;
  logic [CW-1:0]           col_r;
  logic [RW-1:0]           row_r;
  logic [HW-1:0]           eff_height;
  logic                    accept;

  assign cfg_ready = 1'b1;

  // Clamp the register values to the supported frame range
  always_comb begin
    if (frame_width_r < WIDTH_REG_W'(MIN_DIM)) begin
      eff_width = EW'(MIN_DIM);
    end else if (32'(frame_width_r) > 32'(MAX_WIDTH)) begin
      eff_width = EW'(MAX_WIDTH);
    end else begin
      eff_width = EW'(frame_width_r);
    end
    if (frame_height_r < HEIGHT_REG_W'(MIN_DIM)) begin
      eff_height = HW'(MIN_DIM);
    end else if (32'(frame_height_r) > 32'(MAX_HEIGHT)) begin
      eff_height = HW'(MAX_HEIGHT);
    end else begin
      eff_height = HW'(frame_height_r);
    end
  end

  // Classify the pixel at the current raster position
  assign in_tready  = push_ready;
  assign push_valid = in_tvalid;
  assign accept     = in_tvalid && push_ready;
  assign push_pixel = in_tdata[LEVEL_W-1:0];
  assign push_row   = row_r;
  assign push_col   = col_r;

  always_comb begin
    push_flags.emit     = (row_r != '0);
    push_flags.has_up   = (HW'(row_r) >= HW'(2));
    push_flags.row_end  = ((EW'(col_r) + EW'(1)) == eff_width);
    push_flags.last_row = ((HW'(row_r) + HW'(1)) == eff_height);
  end

  // Hold configuration and advance the raster counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= WIDTH_REG_W'(WIDTH_RESET);
      frame_height_r <= HEIGHT_REG_W'(HEIGHT_RESET);
      col_r          <= '0;
      row_r          <= '0;
    end else if (cfg_valid) begin
      if (cfg_index == REG_FRAME_WIDTH) begin
        frame_width_r <= cfg_data[WIDTH_REG_W-1:0];
        col_r         <= '0;
        row_r         <= '0;
      end else if (cfg_index == REG_FRAME_HEIGHT) begin
        frame_height_r <= cfg_data[HEIGHT_REG_W-1:0];
        col_r          <= '0;
        row_r          <= '0;
      end
    end else if (accept) begin
      if (push_flags.row_end) begin
        col_r <= '0;
        row_r <= push_flags.last_row ? '0 : row_r + RW'(1);
      end else begin
        col_r <= col_r + CW'(1);
      end
    end
  end

endmodule

>>> hw/rtl/cnd_queue.sv
// Small FIFO that decouples the classifying front from the filtering back.
module cnd_queue import cnd_pkg::*; #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = QUEUE_DEPTH,
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int NW = $clog2(DEPTH + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_valid,
  output logic              push_ready,
  input  logic [DATA_W-1:0] push_data,
  output logic              pop_valid,
  input  logic              pop_ready,
  output logic [DATA_W-1:0] pop_data
);

  logic [DATA_W-1:0] slot_r [DEPTH];
  logic [PW-1:0]     wr_ptr_r;
  logic [PW-1:0]     rd_ptr_r;
  logic [NW-1:0]     count_r;
  logic              push;
  logic              pop;

  assign push_ready = (count_r != NW'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = slot_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  // Store a transaction at the tail
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wrap_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= wrap_inc(rd_ptr_r);
      end
      if (push && !pop) begin
        count_r <= count_r + NW'(1);
      end else if (pop && !push) begin
        count_r <= count_r - NW'(1);
      end
    end
  end

endmodule

>>> hw/rtl/cnd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module cnd_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/cnd_back.sv
// Back end: rotating line stores, neighbour window, despeckle rule and output register.
module cnd_back import cnd_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
  localparam int CW = $clog2(MAX_WIDTH),
  localparam int RW = (MAX_HEIGHT > 2) ? $clog2(MAX_HEIGHT) : 1,
  localparam int EW = $clog2(MAX_WIDTH + 1)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [EW-1:0]          eff_width,
  input  logic                   q_valid,
  output logic                   q_ready,
  input  level_t                 q_pixel,
  input  logic [RW-1:0]          q_row,
  input  logic [CW-1:0]          q_col,
  input  item_flags_t            q_flags,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [3:0] filtered_level, [10:4] shade_glyph, [20:11] out_row, [25:21] out_col
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tlast,
  output logic                   out_tuser   // [0] frame_last
);

  localparam int NUM_BANKS = 3;
  localparam int BANK_W    = 2;
  localparam int SUM_W     = 7;
  localparam int TAP_W     = 3;
  localparam int PROD_W    = 15;
  localparam int PAD_W     = OUT_TDATA_W - LEVEL_W - GLYPH_W - OUT_ROW_W - OUT_COL_W;
  // Reciprocal constants: exact truncated quotients for any sum below 128
  localparam logic [PROD_W-1:0] DIV3_MUL = 15'd171;
  localparam int                DIV3_SH  = 9;
  localparam logic [PROD_W-1:0] DIV5_MUL = 15'd205;
  localparam int                DIV5_SH  = 10;
  localparam logic [TAP_W-1:0]  TAPS_CORNER = 3'd3;
  localparam logic [TAP_W-1:0]  TAPS_EDGE   = 3'd4;
  localparam logic [TAP_W-1:0]  TAPS_INNER  = 3'd5;

  typedef enum logic [1:0] {ST_IDLE, ST_PRIME, ST_CALC} state_t;

  state_t              state_r, state_nxt;
  logic [BANK_W-1:0]   lower_sel_r, lower_sel_nxt;
  logic [CW-1:0]       k_r, k_nxt;
  logic [RW-1:0]       row_r, row_nxt;
  level_t              dn_r, dn_nxt;
  logic                has_up_r, has_up_nxt;
  logic                row_end_r, row_end_nxt;
  logic                last_row_r, last_row_nxt;
  logic                flush_r, flush_nxt;
  level_t              cl_r, cl_nxt;
  level_t              cc_r, cc_nxt;
  logic [CW-1:0]       rd_c_r, rd_c_nxt;
  logic [CW-1:0]       rd_u_r, rd_u_nxt;
  logic                out_valid_r, out_valid_nxt;
  level_t              out_level_r, out_level_nxt;
  logic [GLYPH_W-1:0]  out_glyph_r, out_glyph_nxt;
  logic [OUT_ROW_W-1:0] out_row_r, out_row_nxt;
  logic [OUT_COL_W-1:0] out_col_r, out_col_nxt;
  logic                out_last_r, out_last_nxt;
  logic                out_flast_r, out_flast_nxt;

  logic                ram_we;
  level_t              bank_rdata [NUM_BANKS];
  logic [BANK_W-1:0]   up_sel, cen_sel, cen_sel_nxt;
  level_t              cen_rdata, up_rdata;
  logic                out_free;
  logic                has_left, has_right, last_col;
  logic                all_high;
  logic [SUM_W-1:0]    sum;
  logic [TAP_W-1:0]    taps;
  level_t              new_level;

  function automatic logic [BANK_W-1:0] next_bank(input logic [BANK_W-1:0] b);
    return (b == BANK_W'(NUM_BANKS - 1)) ? '0 : b + BANK_W'(1);
  endfunction

  // Neighbour is brighter than the pixel by more than one
  function automatic logic exceeds(input level_t nb, input level_t v);
    return {1'b0, nb} > ({1'b0, v} + 5'd1);
  endfunction

  // Truncated mean for three, four or five taps
  function automatic level_t mean_of(input logic [SUM_W-1:0] s, input logic [TAP_W-1:0] n);
    logic [PROD_W-1:0] p3;
    logic [PROD_W-1:0] p5;
    level_t            m;
    p3 = PROD_W'(s) * DIV3_MUL;
    p5 = PROD_W'(s) * DIV5_MUL;
    case (n)
      TAPS_CORNER: m = p3[DIV3_SH +: LEVEL_W];
      TAPS_EDGE:   m = s[2 +: LEVEL_W];
      TAPS_INNER:  m = p5[DIV5_SH +: LEVEL_W];
      default:     m = s[LEVEL_W-1:0];
    endcase
    return m;
  endfunction

  // Bank roles rotate by one at each row end
  assign up_sel      = next_bank(lower_sel_r);
  assign cen_sel     = next_bank(up_sel);
  assign cen_sel_nxt = next_bank(next_bank(lower_sel_nxt));
  assign cen_rdata   = bank_rdata[cen_sel];
  assign up_rdata    = bank_rdata[up_sel];

  // Line stores: write the lower row, read centre and upper rows
  for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
    cnd_ram #(
      .WIDTH (LEVEL_W),
      .DEPTH (MAX_WIDTH)
    ) u_line (
      .clk   (clk),
      .we    (ram_we && (lower_sel_r == BANK_W'(b))),
      .waddr (q_col),
      .wdata (q_pixel),
      .raddr ((cen_sel_nxt == BANK_W'(b)) ? rd_c_nxt : rd_u_nxt),
      .rdata (bank_rdata[b])
    );
  end

  // Apply the despeckle rule to the window around column k
  always_comb begin
    has_left  = (k_r != '0);
    has_right = ((EW'(k_r) + EW'(1)) < eff_width);
    last_col  = ((EW'(k_r) + EW'(1)) == eff_width);
    all_high  = 1'b1;
    sum       = SUM_W'(cc_r);
    taps      = TAP_W'(1);
    if (has_left) begin
      all_high = all_high && exceeds(cl_r, cc_r);
      sum      = sum + SUM_W'(cl_r);
      taps     = taps + TAP_W'(1);
    end
    if (has_right) begin
      all_high = all_high && exceeds(cen_rdata, cc_r);
      sum      = sum + SUM_W'(cen_rdata);
      taps     = taps + TAP_W'(1);
    end
    if (flush_r || has_up_r) begin
      all_high = all_high && exceeds(up_rdata, cc_r);
      sum      = sum + SUM_W'(up_rdata);
      taps     = taps + TAP_W'(1);
    end
    if (!flush_r) begin
      all_high = all_high && exceeds(dn_r, cc_r);
      sum      = sum + SUM_W'(dn_r);
      taps     = taps + TAP_W'(1);
    end
    new_level = all_high ? mean_of(sum, taps) : cc_r;
  end

  assign out_free = !out_valid_r || out_tready;

  // Sequence pops, window priming, filtering and the end-of-frame flush
  always_comb begin
    state_nxt     = state_r;
    lower_sel_nxt = lower_sel_r;
    k_nxt         = k_r;
    row_nxt       = row_r;
    dn_nxt        = dn_r;
    has_up_nxt    = has_up_r;
    row_end_nxt   = row_end_r;
    last_row_nxt  = last_row_r;
    flush_nxt     = flush_r;
    cl_nxt        = cl_r;
    cc_nxt        = cc_r;
    rd_c_nxt      = rd_c_r;
    rd_u_nxt      = rd_u_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_level_nxt = out_level_r;
    out_glyph_nxt = out_glyph_r;
    out_row_nxt   = out_row_r;
    out_col_nxt   = out_col_r;
    out_last_nxt  = out_last_r;
    out_flast_nxt = out_flast_r;
    q_ready       = 1'b0;
    ram_we        = 1'b0;
    case (state_r)
      ST_IDLE: begin
        q_ready = 1'b1;
        if (q_valid) begin
          ram_we       = 1'b1;
          k_nxt        = q_col;
          row_nxt      = q_row;
          dn_nxt       = q_pixel;
          has_up_nxt   = q_flags.has_up;
          row_end_nxt  = q_flags.row_end;
          last_row_nxt = q_flags.last_row;
          if (q_flags.emit) begin
            if (q_col == '0) begin
              rd_c_nxt  = '0;
              state_nxt = ST_PRIME;
            end else begin
              rd_c_nxt  = q_col + CW'(1);
              rd_u_nxt  = q_col;
              state_nxt = ST_CALC;
            end
          end else if (q_flags.row_end) begin
            lower_sel_nxt = next_bank(lower_sel_r);
          end
        end
      end
      ST_PRIME: begin
        cc_nxt    = cen_rdata;
        rd_c_nxt  = k_r + CW'(1);
        rd_u_nxt  = k_r;
        state_nxt = ST_CALC;
      end
      ST_CALC: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_level_nxt = new_level;
          out_glyph_nxt = shade_glyph(new_level);
          out_row_nxt   = flush_r ? OUT_ROW_W'(row_r) : OUT_ROW_W'(row_r - RW'(1));
          out_col_nxt   = OUT_COL_W'(k_r);
          out_last_nxt  = flush_r ? last_col : !(row_end_r && last_row_r);
          out_flast_nxt = flush_r && last_col;
          cl_nxt        = cc_r;
          cc_nxt        = cen_rdata;
          if (flush_r) begin
            if (last_col) begin
              flush_nxt = 1'b0;
              state_nxt = ST_IDLE;
            end else begin
              k_nxt    = k_r + CW'(1);
              rd_c_nxt = k_r + CW'(2);
              rd_u_nxt = k_r + CW'(1);
            end
          end else if (row_end_r) begin
            lower_sel_nxt = next_bank(lower_sel_r);
            if (last_row_r) begin
              flush_nxt = 1'b1;
              k_nxt     = '0;
              rd_c_nxt  = '0;
              state_nxt = ST_PRIME;
            end else begin
              state_nxt = ST_IDLE;
            end
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Hold sequencer state, window and output register
  always_ff @(posedge clk) begin
    k_r           <= k_nxt;
    row_r         <= row_nxt;
    dn_r          <= dn_nxt;
    has_up_r      <= has_up_nxt;
    row_end_r     <= row_end_nxt;
    last_row_r    <= last_row_nxt;
    cl_r          <= cl_nxt;
    cc_r          <= cc_nxt;
    rd_c_r        <= rd_c_nxt;
    rd_u_r        <= rd_u_nxt;
    out_level_r   <= out_level_nxt;
    out_glyph_r   <= out_glyph_nxt;
    out_row_r     <= out_row_nxt;
    out_col_r     <= out_col_nxt;
    out_last_r    <= out_last_nxt;
    out_flast_r   <= out_flast_nxt;
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      lower_sel_r <= '0;
      flush_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      lower_sel_r <= lower_sel_nxt;
      flush_r     <= flush_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {PAD_W'(0), out_col_r, out_row_r, out_glyph_r, out_level_r};
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_flast_r;

  // A flush never rests in the idle state
  a_flush_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !flush_r)
    else $error("flush pending while sequencer idle");

  // Window priming only happens at the first column
  a_prime_col0: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PRIME) |-> (k_r == '0))
    else $error("window primed away from column zero");

  // The frame's final pixel closes its run
  a_frame_last_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_flast_r) |-> out_last_r)
    else $error("frame end without run end");

  // Bank selector cycles through the three line stores only
  a_bank_range: assert property (@(posedge clk) disable iff (!rst_n)
    lower_sel_r != BANK_W'(NUM_BANKS))
    else $error("line store selector out of range");

endmodule

>>> tb/cross_neighbour_despeckle_tb.sv
// Self-checking testbench for the cross-neighbour despeckle filter: directed frames, then random frames.
module cross_neighbour_despeckle_tb;
  import cnd_pkg::*;

  localparam int IDLE_PCT      = 32;
  localparam int SETTLE_CYCLES = 20;
  localparam int HOLD_CYCLES   = 300;
  localparam int STALL_LIMIT   = 2000;
  localparam int RANDOM_ITEMS  = 420;
  localparam int PRINT_LIMIT   = 40;
  localparam int LAST_SHADE    = 9;

  // Register indexes the block does not decode
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_B = 2'd3;

  // Result field positions inside out_tdata
  localparam int GLYPH_LSB = LEVEL_W;
  localparam int ROW_LSB   = GLYPH_LSB + GLYPH_W;
  localparam int COL_LSB   = ROW_LSB + OUT_ROW_W;

  localparam string SHADES = " .':~*=&%#";

  // Frame settings walked first in the random part: extremes and clamped values
  localparam int NUM_FIXED = 5;
  localparam int FIXED_W      [NUM_FIXED] = '{63, 32, 33, 2, 1};
  localparam int FIXED_H      [NUM_FIXED] = '{2, 3, 0, 2047, 1025};
  localparam int FIXED_FRAMES [NUM_FIXED] = '{2, 1, 1, 0, 0};

  typedef enum logic {ROW_CFG, ROW_PIX} step_kind_t;

  typedef struct packed {
    step_kind_t             kind;
    logic [CFG_INDEX_W-1:0] idx;
    logic [CFG_DATA_W-1:0]  value;
    logic                   check;  // first result level typed in below
    level_t                 typed;
  } step_t;

  typedef struct packed {
    level_t                level;
    logic [GLYPH_W-1:0]    glyph;
    logic [OUT_ROW_W-1:0]  row;
    logic [OUT_COL_W-1:0]  col;
    logic                  run_last;
    logic                  frame_last;
  } despeckled_t;

  // Directed frames: 2x2 corner cases, 3x3 with a centre speckle, 2x4 with an edge speckle
  localparam int SCRIPT_LEN = 33;
  localparam step_t SCRIPT [SCRIPT_LEN] = '{
    '{ROW_CFG, REG_FRAME_WIDTH,  11'h7c0, 1'b0, 4'd0},
    '{ROW_CFG, REG_FRAME_HEIGHT, 11'd1,   1'b0, 4'd0},
    '{ROW_PIX, '0, 11'd0,  1'b0, 4'd0},
    '{ROW_PIX, '0, 11'd15, 1'b0, 4'd0},
    '{ROW_PIX, '0, 11'd15, 1'b1, 4'd10},
    '{ROW_PIX, '0, 11'd15, 1'b1, 4'd15},
    '{ROW_PIX, '0, 11'd15, 1'b0, 4'd0},
    '{ROW_PIX, '0, 11'd15, 1'b0, 4'd0},
    '{ROW_PIX, '0, 11'd15, 1'b1, 4'd15},
    '{ROW_PIX, '0, 11'd0,  1'b1, 4'd15},
    '{ROW_CFG, REG_FRAME_WIDTH,  11'd3,   1'b0, 4'd0},
    '{ROW_CFG, REG_FRAME_HEIGHT, 11'd3,   1'b0, 4'd0},
    '{ROW_PIX, '0, 11'd9,  1'b0, 4'd0},
    '{ROW_PIX, '0, 11'd9,  1'b0, 4'd0},
    '{ROW_PIX, '0, 11'd9,  1'b0, 4'd0},
    '{ROW_CFG, REG_SPARE_A,      11'h7ff, 1'b0, 4'd0},
    '{ROW_PIX, '0, 11'd9,  1'b0, 4'd0},
    '{ROW_PIX, '0, 11'd0,  1'b0, 4'd0},
    '{ROW_PIX, '0, 11'd9,  1'b0, 4'd0},
    '{ROW_PIX, '0, 11'd9,  1'b0, 4'd0},
    '{ROW_PIX, '0, 11'd9,  1'b1, 4'd7},
    '{ROW_PIX, '0, 11'd9,  1'b1, 4'd9},
    '{ROW_CFG, REG_FRAME_WIDTH,  11'd2,   1'b0, 4'd0},
    '{ROW_CFG, REG_FRAME_HEIGHT, 11'd4,   1'b0, 4'd0},
    '{ROW_CFG, REG_SPARE_B,      11'd0,   1'b0, 4'd0},
    '{ROW_PIX, '0, 11'd8,  1'b0, 4'd0},
    '{ROW_PIX, '0, 11'd8,  1'b0, 4'd0},
    '{ROW_PIX, '0, 11'd0,  1'b0, 4'd0},
    '{ROW_PIX, '0, 11'd9,  1'b0, 4'd0},
    '{ROW_PIX, '0, 11'd8,  1'b1, 4'd6},
    '{ROW_PIX, '0, 11'd8,  1'b0, 4'd0},
    '{ROW_PIX, '0, 11'd7,  1'b0, 4'd0},
    '{ROW_PIX, '0, 11'd8,  1'b0, 4'd0}
  };

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;    // [3:0] pixel_level
  logic                   out_tvalid;
  logic                   out_tready;
  // [3:0] filtered_level, [10:4] shade_glyph, [20:11] out_row, [25:21] out_col
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;   // run_last
  logic                   out_tuser;   // [0] frame_last
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  // Shadow of the filter: line stores, raster position, registers
  level_t                  row_above [MAX_WIDTH_DEF];
  level_t                  row_mid   [MAX_WIDTH_DEF];
  level_t                  row_new   [MAX_WIDTH_DEF];
  int                      next_row;
  int                      next_col;
  logic [WIDTH_REG_W-1:0]  width_reg;
  logic [HEIGHT_REG_W-1:0] height_reg;

  despeckled_t expected_pixels[$];
  int          error_count  = 0;
  int          results_seen = 0;
  int          quiet_cycles = 0;
  logic        steady_flow;

  cross_neighbour_despeckle DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int active_width();
    int w;
    w = width_reg;
    if (w < MIN_DIM) w = MIN_DIM;
    if (w > MAX_WIDTH_DEF) w = MAX_WIDTH_DEF;
    return w;
  endfunction

  function automatic int active_height();
    int h;
    h = height_reg;
    if (h < MIN_DIM) h = MIN_DIM;
    if (h > MAX_HEIGHT_DEF) h = MAX_HEIGHT_DEF;
    return h;
  endfunction

  function automatic logic [GLYPH_W-1:0] glyph_for(input level_t lv);
    byte ch;
    ch = (lv <= LAST_SHADE) ? SHADES[int'(lv)] : SHADES[0];
    return ch[GLYPH_W-1:0];
  endfunction

  // Average with the existing neighbours when all of them sit more than one level above
  function automatic level_t despeckle_level(input int c, input int w, input bit up,
                                             input bit down);
    int centre;
    int total;
    bit all_high;
    int nbrs[$];
    centre   = row_mid[c];
    total    = centre;
    all_high = 1'b1;
    if (c > 0) nbrs.push_back(row_mid[c-1]);
    if (c + 1 < w) nbrs.push_back(row_mid[c+1]);
    if (up) nbrs.push_back(row_above[c]);
    if (down) nbrs.push_back(row_new[c]);
    foreach (nbrs[i]) begin
      if (nbrs[i] <= centre + 1) all_high = 1'b0;
      total += nbrs[i];
    end
    return all_high ? level_t'(total / (nbrs.size() + 1)) : level_t'(centre);
  endfunction

  function automatic despeckled_t make_result(input level_t lv, input int r, input int c,
                                              input bit frame_end);
    despeckled_t d;
    d.level      = lv;
    d.glyph      = glyph_for(lv);
    d.row        = r[OUT_ROW_W-1:0];
    d.col        = c[OUT_COL_W-1:0];
    d.run_last   = 1'b0;
    d.frame_last = frame_end;
    return d;
  endfunction

  // Advance the shadow by one pixel and queue the results it releases
  function automatic void predict_pixel(input level_t lv, input bit check, input level_t typed);
    despeckled_t fresh[$];
    int w;
    int h;
    int r;
    int c;
    w = active_width();
    h = active_height();
    r = next_row;
    c = next_col;
    if (r >= h || c >= w) begin
      r = 0;
      c = 0;
    end
    row_new[c] = lv;
    if (r >= 1) fresh.push_back(make_result(despeckle_level(c, w, r >= 2, 1'b1), r - 1, c, 1'b0));
    if (c + 1 == w) begin
      row_above = row_mid;
      row_mid   = row_new;
      if (r + 1 == h) begin
        // flush the bottom row, which has no row below
        for (int k = 0; k < w; k++)
          fresh.push_back(make_result(despeckle_level(k, w, 1'b1, 1'b0), r, k, k + 1 == w));
        next_row = 0;
      end else begin
        next_row = r + 1;
      end
      next_col = 0;
    end else begin
      next_row = r;
      next_col = c + 1;
    end
    if (fresh.size() > 0) begin
      fresh[fresh.size()-1].run_last = 1'b1;
      if (check) begin
        fresh[0].level = typed;
        fresh[0].glyph = glyph_for(typed);
      end
    end
    foreach (fresh[i]) expected_pixels.push_back(fresh[i]);
  endfunction

  function automatic void apply_config(input logic [CFG_INDEX_W-1:0] idx,
                                       input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_FRAME_WIDTH: begin
        width_reg = data[WIDTH_REG_W-1:0];
        next_row  = 0;
        next_col  = 0;
      end
      REG_FRAME_HEIGHT: begin
        height_reg = data[HEIGHT_REG_W-1:0];
        next_row   = 0;
        next_col   = 0;
      end
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want,
                                 input int row, input int col);
    error_count++;
    if (error_count <= PRINT_LIMIT)
      $display("MISMATCH %s at row %0d col %0d: got %0d, expected %0d",
               what, row, col, got, want);
  endtask

  // Offer one pixel, with random gaps before it, and predict on acceptance
  task automatic send_pixel(input level_t lv, input bit check, input level_t typed);
    while (!steady_flow && $urandom_range(0, 99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_TDATA_W - LEVEL_W){1'b0}}, lv};
    do @(posedge clk); while (in_tready !== 1'b1);
    predict_pixel(lv, check, typed);
    @(negedge clk);
  endtask

  // Drop valid, wait for every pending result, then let the pipeline empty
  task automatic settle();
    in_tvalid <= 1'b0;
    while (expected_pixels.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int value);
    settle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[CFG_DATA_W-1:0];
    do @(posedge clk); while (cfg_ready !== 1'b1);
    apply_config(idx, value[CFG_DATA_W-1:0]);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Flat background with random outliers, so that speckles appear often
  task automatic send_frame(input int count, input int pause_at);
    level_t base;
    level_t lv;
    base = $urandom_range(0, 15);
    for (int i = 0; i < count; i++) begin
      if (i == pause_at) settle();
      if ($urandom_range(0, 3) == 0) lv = $urandom_range(0, 15);
      else lv = base ^ level_t'($urandom_range(0, 1));
      send_pixel(lv, 1'b0, '0);
    end
  endtask

  // Result side: random stalls, plus two long hold-offs that back the block up
  initial begin
    int holds_done;
    holds_done = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      // start a hold-off only while the sender is offering pixels
      if (holds_done < 2 && in_tvalid && results_seen >= (holds_done == 0 ? 150 : 400)) begin
        holds_done++;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_tready <= steady_flow || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // Check each result transaction against the oldest prediction
  always @(posedge clk) begin
    despeckled_t want;
    if (rst_n && out_tvalid === 1'b1 && out_tready) begin
      results_seen++;
      if (expected_pixels.size() == 0) begin
        report_mismatch("unpredicted result, level", out_tdata[LEVEL_W-1:0], -1,
                        out_tdata[ROW_LSB +: OUT_ROW_W], out_tdata[COL_LSB +: OUT_COL_W]);
      end else begin
        want = expected_pixels.pop_front();
        if (out_tdata[LEVEL_W-1:0] !== want.level)
          report_mismatch("filtered_level", out_tdata[LEVEL_W-1:0], want.level,
                          want.row, want.col);
        if (out_tdata[GLYPH_LSB +: GLYPH_W] !== want.glyph)
          report_mismatch("shade_glyph", out_tdata[GLYPH_LSB +: GLYPH_W], want.glyph,
                          want.row, want.col);
        if (out_tdata[ROW_LSB +: OUT_ROW_W] !== want.row)
          report_mismatch("out_row", out_tdata[ROW_LSB +: OUT_ROW_W], want.row,
                          want.row, want.col);
        if (out_tdata[COL_LSB +: OUT_COL_W] !== want.col)
          report_mismatch("out_col", out_tdata[COL_LSB +: OUT_COL_W], want.col,
                          want.row, want.col);
        if (out_tlast !== want.run_last)
          report_mismatch("run_last", out_tlast, want.run_last, want.row, want.col);
        if (out_tuser !== want.frame_last)
          report_mismatch("frame_last", out_tuser, want.frame_last, want.row, want.col);
      end
    end
  end

  // End the run when no transaction of any kind completes for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    step_t st;
    int random_items;
    int ph;
    int wd;
    int hd;
    int frames;
    int area;
    int n;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    cfg_valid   = 1'b0;
    cfg_index   = REG_FRAME_WIDTH;
    cfg_data    = '0;
    steady_flow = 1'b0;
    width_reg   = WIDTH_RESET;
    height_reg  = HEIGHT_RESET;
    next_row    = 0;
    next_col    = 0;
    foreach (row_new[i]) begin
      row_above[i] = '0;
      row_mid[i]   = '0;
      row_new[i]   = '0;
    end
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed frames
    foreach (SCRIPT[i]) begin
      st = SCRIPT[i];
      if (st.kind == ROW_CFG) write_reg(st.idx, st.value);
      else send_pixel(st.value[LEVEL_W-1:0], st.check, st.typed);
    end

    // Extreme settings first, then random small frames; frames at the full clamped height are not counted
    random_items = 0;
    ph = 0;
    while (random_items < RANDOM_ITEMS) begin
      if (ph < NUM_FIXED) begin
        wd     = FIXED_W[ph];
        hd     = FIXED_H[ph];
        frames = FIXED_FRAMES[ph];
      end else begin
        wd     = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 2047) : $urandom_range(2, 12);
        hd     = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 7) : $urandom_range(2, 6);
        frames = $urandom_range(1, 3);
      end
      write_reg(REG_FRAME_WIDTH, wd);
      write_reg(REG_FRAME_HEIGHT, hd);
      steady_flow <= (ph == 1 || ph == NUM_FIXED);
      area = active_width() * active_height();
      for (int f = 0; f < frames; f++) begin
        n = area;
        // abandon the last frame of some phases; the next write restarts the raster
        if (ph >= NUM_FIXED && f == frames - 1 && $urandom_range(0, 4) == 0)
          n = $urandom_range(1, area - 1);
        send_frame(n, (ph == NUM_FIXED && f == 0) ? area / 2 : -1);
        if (active_height() < MAX_HEIGHT_DEF) random_items += n;
        if ($urandom_range(0, 9) == 0)
          write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, $urandom_range(0, 2047));
      end
      if (frames == 0) send_frame(20, -1);
      ph++;
    end

    settle();
    if (error_count == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
